[rtl/timed_pump_valve_sequencer_unit_defines.svh]
// assertion macros shared by the sequencer checker
`ifndef TIMED_PUMP_VALVE_SEQUENCER_UNIT_DEFINES_SVH
`define TIMED_PUMP_VALVE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define TPVS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// next-cycle implication, sampled on aclk, off during reset
`define TPVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

[rtl/tpvs_pkg.sv]
// types, codes and constants of the pump and valve sequencer
`default_nettype none

package tpvs_pkg;

    localparam int TICKS_PER_SECOND = 10;

    localparam int SEC_W   = 8;
    localparam int TICKS_W = 12;
    localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

    localparam int PROD_RAW_W = SEC_W + $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W     = (PROD_RAW_W > TICKS_W) ? PROD_RAW_W : TICKS_W + 1;

    localparam logic [SEC_W-1:0] MAX_DURATION_RESET = 8'd60;
    localparam logic [SEC_W-1:0] MIN_INFLATE_RESET  = 8'd1;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DURATION = 2'd0,
        CFG_MIN_INFLATE  = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_STOP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ACT_HOLD    = 2'd0,
        ACT_INFLATE = 2'd1,
        ACT_DEFLATE = 2'd2,
        ACT_UNKNOWN = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ZONE_LEFT    = 2'd0,
        ZONE_RIGHT   = 2'd1,
        ZONE_BOTH    = 2'd2,
        ZONE_UNKNOWN = 2'd3
    } zone_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_INFLATE = 2'd1,
        MODE_DEFLATE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_STARTED    = 3'd1,
        ST_FINISHED   = 3'd2,
        ST_CANCELLED  = 3'd3,
        ST_BAD_ACTION = 3'd4,
        ST_BAD_ZONE   = 3'd5,
        ST_BUSY       = 3'd6
    } status_t;

    typedef struct packed {
        logic [SEC_W-1:0] max_duration_sec;
        logic [SEC_W-1:0] min_inflate_sec;
    } cfg_t;

    typedef struct packed {
        kind_t            kind;
        action_t          action;
        zone_t            zone;
        logic [SEC_W-1:0] run_secs;
    } item_t;

    typedef struct packed {
        status_t status;
        logic    busy_res;
        logic    valve_right_pin;
        logic    valve_left_pin;
        logic    pump_right_pin;
        logic    pump_left_pin;
    } result_t;

endpackage

`default_nettype wire

[rtl/tpvs_cfg.sv]
// configuration registers of the sequencer
`default_nettype none

module tpvs_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [tpvs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tpvs_pkg::SEC_W-1:0]     cfg_data,
    output tpvs_pkg::cfg_t                      cfg
);
    import tpvs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_DURATION: cfg_next.max_duration_sec = cfg_data;
                CFG_MIN_INFLATE:  cfg_next.min_inflate_sec  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_duration_sec <= MAX_DURATION_RESET;
            cfg_reg.min_inflate_sec  <= MIN_INFLATE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/tpvs_core.sv]
// run state and per-item update of the sequencer
`default_nettype none

module tpvs_core (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step,
    input  wire tpvs_pkg::item_t item,
    input  wire tpvs_pkg::cfg_t  cfg,
    output tpvs_pkg::result_t result
);
    import tpvs_pkg::*;

    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    mode_t              mode_reg, mode_next;
    zone_t              zone_reg, zone_next;

    logic [SEC_W-1:0]   secs;
    logic [PROD_W-1:0]  prod;
    logic [TICKS_W-1:0] run_ticks;
    logic [TICKS_W-1:0] ticks_dec;
    status_t            status;
    logic               side_l, side_r, inf, def;

    always_comb begin
        secs = item.run_secs;
        if (item.action == ACT_INFLATE && secs < cfg.min_inflate_sec) begin
            secs = cfg.min_inflate_sec;
        end
        if (secs > cfg.max_duration_sec) begin
            secs = cfg.max_duration_sec;
        end
        prod = PROD_W'(secs) * PROD_W'(TICKS_PER_SECOND);
        run_ticks = (prod > PROD_W'(TICKS_MAX)) ? TICKS_MAX : prod[TICKS_W-1:0];
        ticks_dec = (ticks_reg != '0) ? ticks_reg - TICKS_W'(1) : ticks_reg;
    end

    always_comb begin
        ticks_next = ticks_reg;
        mode_next  = mode_reg;
        zone_next  = zone_reg;
        status     = ST_NONE;
        case (item.kind)
            KIND_TICK: begin
                if (mode_reg != MODE_IDLE) begin
                    ticks_next = ticks_dec;
                    if (ticks_dec == '0) begin
                        mode_next = MODE_IDLE;
                        zone_next = ZONE_LEFT;
                        status    = ST_FINISHED;
                    end
                end
            end
            KIND_CMD: begin
                if (mode_reg != MODE_IDLE) begin
                    status = ST_BUSY;
                end else if (item.action == ACT_HOLD) begin
                    status = ST_NONE;
                end else if (item.action == ACT_UNKNOWN) begin
                    status = ST_BAD_ACTION;
                end else if (item.zone == ZONE_UNKNOWN) begin
                    status = ST_BAD_ZONE;
                end else if (run_ticks == '0) begin
                    ticks_next = '0;
                    mode_next  = MODE_IDLE;
                    zone_next  = ZONE_LEFT;
                    status     = ST_FINISHED;
                end else begin
                    ticks_next = run_ticks;
                    mode_next  = (item.action == ACT_INFLATE) ? MODE_INFLATE : MODE_DEFLATE;
                    zone_next  = item.zone;
                    status     = ST_STARTED;
                end
            end
            KIND_STOP: begin
                ticks_next = '0;
                mode_next  = MODE_IDLE;
                zone_next  = ZONE_LEFT;
                status     = ST_CANCELLED;
            end
            default: ;
        endcase
    end

    // pins follow the state left by this item
    always_comb begin
        side_l = (zone_next == ZONE_BOTH) || (zone_next == ZONE_LEFT);
        side_r = (zone_next == ZONE_BOTH) || (zone_next == ZONE_RIGHT);
        inf    = (mode_next == MODE_INFLATE);
        def    = (mode_next == MODE_DEFLATE);
        result.pump_left_pin   = !(inf && side_l);
        result.pump_right_pin  = !(inf && side_r);
        result.valve_left_pin  = def && side_l;
        result.valve_right_pin = def && side_r;
        result.busy_res        = (mode_next != MODE_IDLE);
        result.status          = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= '0;
            mode_reg  <= MODE_IDLE;
            zone_reg  <= ZONE_LEFT;
        end else if (step) begin
            ticks_reg <= ticks_next;
            mode_reg  <= mode_next;
            zone_reg  <= zone_next;
        end
    end

endmodule

`default_nettype wire

[rtl/timed_pump_valve_sequencer_unit.sv]
// pipeline: two register stages, the input register and the result register; a transaction
// taken on the slave side waits in the input register and moves on once the result register is free
// throughput: one item per cycle while the master side keeps taking results, set by the single
// update of the run state between the input register and the result register
// reset: aresetn synchronous active low; run idle, no result pending, max 60 s, min inflate 1 s
// no clearing pass: the block takes items from the first cycle after reset
`default_nettype none

module timed_pump_valve_sequencer_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // slave side
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [15:0]                    s_tdata,  // action[1:0] zone[3:2] run_secs[11:4]
    input  wire logic [1:0]                     s_tuser,  // kind[1:0]
    // master side
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,  // pump_left_pin[0] pump_right_pin[1]
                                                          // valve_left_pin[2] valve_right_pin[3]
                                                          // busy_res[4] status[7:5]
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tpvs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tpvs_pkg::SEC_W-1:0]     cfg_data
);
    import tpvs_pkg::*;

    // input register
    logic    in_valid_reg;
    item_t   in_item_reg;
    // result register
    logic    out_valid_reg;
    result_t out_res_reg;

    cfg_t    cfg;
    result_t result;
    logic    out_free;
    logic    step;

    // the result register frees up when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    // the held item moves on into the result register
    assign step     = in_valid_reg && out_free;
    // a new item can come in whenever the held one leaves
    assign s_tready = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload holds until replaced, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.kind     <= kind_t'(s_tuser[1:0]);
            in_item_reg.action   <= action_t'(s_tdata[1:0]);
            in_item_reg.zone     <= zone_t'(s_tdata[3:2]);
            in_item_reg.run_secs <= s_tdata[11:4];
        end
    end

    tpvs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state commits on the same edge that captures the result
    tpvs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.status, out_res_reg.busy_res,
                       out_res_reg.valve_right_pin, out_res_reg.valve_left_pin,
                       out_res_reg.pump_right_pin, out_res_reg.pump_left_pin};

endmodule

`default_nettype wire

[rtl/tpvs_checker.sv]
// port-level checks of the sequencer, bound to the top level
`default_nettype none

`include "timed_pump_valve_sequencer_unit_defines.svh"

module tpvs_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);
    import tpvs_pkg::*;

    logic    left_clash;
    logic    right_clash;
    status_t res_status;

    assign left_clash  = !m_tdata[0] && m_tdata[2];
    assign right_clash = !m_tdata[1] && m_tdata[3];
    assign res_status  = status_t'(m_tdata[7:5]);

    // pump and valve of one side never on together
    `TPVS_ASSERT_NOW(a_side_exclusive, m_tvalid, !(left_clash || right_clash))
    // an idle result leaves every actuator off
    `TPVS_ASSERT_NOW(a_idle_off, m_tvalid && !m_tdata[4], m_tdata[3:0] == 4'b0011)
    // cancelled and finished reports never leave a run active
    `TPVS_ASSERT_NOW(a_stop_idle, m_tvalid && (res_status inside {ST_CANCELLED, ST_FINISHED}) == 1'b1, !m_tdata[4])
    // a stalled result transaction holds
    `TPVS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // with no result waiting the input is always open
    `TPVS_ASSERT_NOW(a_in_open, !m_tvalid, s_tready)
endmodule

bind timed_pump_valve_sequencer_unit tpvs_checker u_tpvs_checker (.*);

`default_nettype wire

[bench/timed_pump_valve_sequencer_unit_checker.sv]
`timescale 1ns / 1ps
// checker that tracks the sequencer run state and compares every result transaction
module timed_pump_valve_sequencer_unit_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [15:0]                    s_tdata,  // action[1:0] zone[3:2] run_secs[11:4]
    input  wire logic [1:0]                     s_tuser,  // kind[1:0]
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [7:0]                     m_tdata,  // pump_left_pin[0] pump_right_pin[1]
                                                          // valve_left_pin[2] valve_right_pin[3]
                                                          // busy_res[4] status[7:5]
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [tpvs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tpvs_pkg::SEC_W-1:0]     cfg_data,
    output int                                  mismatches,
    output int                                  results_due,
    output int                                  results_checked
);
    import tpvs_pkg::*;

    localparam int PRINT_CAP = 40;

    logic [SEC_W-1:0]   cap_sec;
    logic [SEC_W-1:0]   floor_sec;
    logic [TICKS_W-1:0] ticks_left;
    mode_t              run_mode;
    zone_t              run_zone;
    result_t            pins_due[$];
    result_t            fresh;
    result_t            oldest;
    result_t            seen;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("mismatch in %s at %0t ns: got %0d, want %0d", what, $time, got, want);
        mismatches++;
    endtask

    task automatic clear_run();
        ticks_left = '0;
        run_mode   = MODE_IDLE;
        run_zone   = ZONE_LEFT;
    endtask

    // one item in, new run state and the pin levels after it out
    task automatic step_sequencer(input logic [1:0] kind, input action_t act, input zone_t zn,
                                  input logic [SEC_W-1:0] dur, output result_t res);
        status_t st;
        int      secs;
        int      run_ticks;
        logic    inf;
        logic    def;
        logic    left_on;
        logic    right_on;
        st = ST_NONE;
        case (kind)
            KIND_TICK: begin
                if (run_mode != MODE_IDLE) begin
                    if (ticks_left != 0)
                        ticks_left = ticks_left - 1'b1;
                    if (ticks_left == 0) begin
                        clear_run();
                        st = ST_FINISHED;
                    end
                end
            end
            KIND_CMD: begin
                if (run_mode != MODE_IDLE) begin
                    st = ST_BUSY;
                end else if (act == ACT_HOLD) begin
                    st = ST_NONE;
                end else if (act == ACT_UNKNOWN) begin
                    st = ST_BAD_ACTION;
                end else if (zn == ZONE_UNKNOWN) begin
                    st = ST_BAD_ZONE;
                end else begin
                    secs = dur;
                    // the floor applies to inflate only, then the cap always wins
                    if (act == ACT_INFLATE && secs < floor_sec)
                        secs = floor_sec;
                    if (secs > cap_sec)
                        secs = cap_sec;
                    run_ticks = secs * TICKS_PER_SECOND;
                    if (run_ticks > int'(TICKS_MAX))
                        run_ticks = TICKS_MAX;
                    if (run_ticks == 0) begin
                        clear_run();
                        st = ST_FINISHED;
                    end else begin
                        ticks_left = run_ticks[TICKS_W-1:0];
                        run_mode   = mode_t'(act);
                        run_zone   = zn;
                        st         = ST_STARTED;
                    end
                end
            end
            KIND_STOP: begin
                clear_run();
                st = ST_CANCELLED;
            end
            default: ;
        endcase
        inf      = (run_mode == MODE_INFLATE);
        def      = (run_mode == MODE_DEFLATE);
        left_on  = (run_zone == ZONE_BOTH) || (run_zone == ZONE_LEFT);
        right_on = (run_zone == ZONE_BOTH) || (run_zone == ZONE_RIGHT);
        res.pump_left_pin   = !(inf && left_on);
        res.pump_right_pin  = !(inf && right_on);
        res.valve_left_pin  = def && left_on;
        res.valve_right_pin = def && right_on;
        res.busy_res        = (run_mode != MODE_IDLE);
        res.status          = st;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cap_sec         = MAX_DURATION_RESET;
            floor_sec       = MIN_INFLATE_RESET;
            clear_run();
            pins_due.delete();
            mismatches      = 0;
            results_due     = 0;
            results_checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAX_DURATION: cap_sec = cfg_data;
                    CFG_MIN_INFLATE:  floor_sec = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                step_sequencer(s_tuser, action_t'(s_tdata[1:0]), zone_t'(s_tdata[3:2]),
                               s_tdata[11:4], fresh);
                pins_due.push_back(fresh);
            end
            if (m_tvalid && m_tready) begin
                seen = result_t'(m_tdata);
                if (pins_due.size() == 0) begin
                    report_mismatch("result with nothing pending", m_tdata, 0);
                end else begin
                    oldest = pins_due.pop_front();
                    if (seen.pump_left_pin !== oldest.pump_left_pin)
                        report_mismatch("pump_left_pin", seen.pump_left_pin,
                                        oldest.pump_left_pin);
                    if (seen.pump_right_pin !== oldest.pump_right_pin)
                        report_mismatch("pump_right_pin", seen.pump_right_pin,
                                        oldest.pump_right_pin);
                    if (seen.valve_left_pin !== oldest.valve_left_pin)
                        report_mismatch("valve_left_pin", seen.valve_left_pin,
                                        oldest.valve_left_pin);
                    if (seen.valve_right_pin !== oldest.valve_right_pin)
                        report_mismatch("valve_right_pin", seen.valve_right_pin,
                                        oldest.valve_right_pin);
                    if (seen.busy_res !== oldest.busy_res)
                        report_mismatch("busy_res", seen.busy_res, oldest.busy_res);
                    if (seen.status !== oldest.status)
                        report_mismatch("status", seen.status, oldest.status);
                    results_checked++;
                end
            end
            results_due = pins_due.size();
        end
    end

endmodule

[bench/timed_pump_valve_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
// stimulus, idling, watchdog and verdict for the pump and valve sequencer
module timed_pump_valve_sequencer_unit_tb;
    import tpvs_pkg::*;

    // pipeline depth of the block, per the block's header
    localparam int PIPE_LATENCY = 2;
    // receiver hold-off long enough to back the block up into its input
    localparam int LONG_HOLD    = 300;
    // cycles with no transaction on any channel before the run is declared hung
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int PHASES       = 6;
    // kind code the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;  // action[1:0] zone[3:2] run_secs[11:4]
    logic [1:0]           s_tuser   = '0;  // kind[1:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;         // pump_left_pin[0] pump_right_pin[1]
                                           // valve_left_pin[2] valve_right_pin[3]
                                           // busy_res[4] status[7:5]
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_DURATION;
    logic [SEC_W-1:0]     cfg_data  = '0;

    int mismatches;
    int results_due;
    int results_checked;

    int items_sent    = 0;
    int settings_used = 0;
    int idle_cycles   = 0;
    int hold_asked    = 0;
    int hold_done     = 0;
    int tx_steady     = 0;
    int rx_steady     = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    timed_pump_valve_sequencer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // prediction and comparison live in the checker; the top only drives and judges
    timed_pump_valve_sequencer_unit_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .results_due     (results_due),
        .results_checked (results_checked)
    );

    // gap before the next transaction; now and then a stretch with no gaps at all
    function automatic int draw_gap(inout int steady);
        if (steady > 0) begin
            steady--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            steady = $urandom_range(20, 60);
        return $urandom_range(0, 10);
    endfunction

    // offer one item after a random gap and return at the edge that takes it;
    // with no gap tvalid simply stays high and only the payload changes
    task automatic push_item(input logic [1:0] kind, input logic [1:0] act,
                             input logic [1:0] zn, input logic [7:0] dur);
        int gap;
        gap = draw_gap(tx_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, dur, zn, act};
        do @(posedge aclk); while (!s_tready);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    // sender goes quiet until the checker holds no expectation; the count is
    // read at the falling edge so it never races the checker's update
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_due != 0);
        @(posedge aclk);
    endtask

    // both limit registers, written back to back while nothing is in flight
    task automatic program_limits(input logic [7:0] cap, input logic [7:0] floor_v);
        wait_drained();
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_DURATION;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_MIN_INFLATE;
        cfg_data  <= floor_v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly a well-formed run: a command, a train of ticks with some noise
    // mixed in, maybe a stop; otherwise a single item of pure noise
    task automatic run_episode();
        int          ticks_planned;
        logic [7:0]  dur;
        logic [1:0]  act;
        if ($urandom_range(0, 15) < 11) begin
            // short runs mostly so that most of them finish on their own
            dur = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 4))
                                              : 8'($urandom_range(0, 255));
            act = $urandom_range(0, 1) ? ACT_INFLATE : ACT_DEFLATE;
            push_item(KIND_CMD, act, 2'($urandom_range(0, 2)), dur);
            ticks_planned = $urandom_range(5, 45);
            repeat (ticks_planned) begin
                case ($urandom_range(0, 39))
                    0, 1:    push_item(KIND_CMD, 2'($urandom), 2'($urandom), 8'($urandom));
                    2:       push_item(KIND_STOP, 2'($urandom), 2'($urandom), 8'($urandom));
                    3:       push_item(KIND_UNUSED, 2'($urandom), 2'($urandom), 8'($urandom));
                    default: push_item(KIND_TICK, 2'($urandom), 2'($urandom), 8'($urandom));
                endcase
            end
            if ($urandom_range(0, 1))
                push_item(KIND_STOP, 2'($urandom), 2'($urandom), 8'($urandom));
        end else begin
            push_item(2'($urandom_range(0, 2)), 2'($urandom), 2'($urandom), 8'($urandom));
        end
    endtask

    // result side: random readiness per transaction, plus the long hold-off on request
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (hold_asked != hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done++;
            end
            gap = draw_gap(rx_steady);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // watchdog: any transaction on any channel counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles, run hung", STALL_LIMIT);
            $display("timed_pump_valve_sequencer_unit verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         phase;
        int         target;
        logic [7:0] cap;
        logic [7:0] floor_v;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, under the reset limits of 60 s cap and 1 s inflate floor
        push_item(KIND_TICK, ACT_HOLD, ZONE_LEFT, 8'd0);            // tick while idle
        push_item(KIND_STOP, ACT_HOLD, ZONE_LEFT, 8'd0);            // stop while idle
        push_item(KIND_CMD, ACT_HOLD, ZONE_LEFT, 8'hff);            // hold while idle
        push_item(KIND_CMD, ACT_UNKNOWN, ZONE_BOTH, 8'd5);          // bad action
        push_item(KIND_CMD, ACT_INFLATE, ZONE_UNKNOWN, 8'd5);       // bad zone
        push_item(KIND_CMD, ACT_INFLATE, ZONE_LEFT, 8'd0);          // raised to the floor
        push_item(KIND_CMD, ACT_HOLD, ZONE_RIGHT, 8'd3);            // hold while busy
        push_item(KIND_STOP, ACT_UNKNOWN, ZONE_UNKNOWN, 8'hff);     // cancel a run
        push_item(KIND_CMD, ACT_DEFLATE, ZONE_BOTH, 8'd0);          // zero-length run
        push_item(KIND_CMD, ACT_DEFLATE, ZONE_RIGHT, 8'hff);        // cut to the cap
        push_item(KIND_CMD, ACT_INFLATE, ZONE_BOTH, 8'd1);          // command while busy
        push_item(KIND_UNUSED, ACT_UNKNOWN, ZONE_UNKNOWN, 8'hff);   // ignored kind
        push_item(KIND_STOP, ACT_HOLD, ZONE_LEFT, 8'd0);
        push_item(KIND_CMD, ACT_INFLATE, ZONE_RIGHT, 8'd1);         // one second run
        repeat (10)
            push_item(KIND_TICK, ACT_HOLD, ZONE_LEFT, 8'd0);        // finishes on the last
        push_item(KIND_TICK, ACT_DEFLATE, ZONE_BOTH, 8'haa);        // idle again

        // random part over several limit settings, extremes included
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin cap = MAX_DURATION_RESET; floor_v = MIN_INFLATE_RESET; end
                1:       begin cap = 8'd1;   floor_v = 8'd0;   end
                2:       begin cap = 8'd255; floor_v = 8'd255; end
                3:       begin cap = 8'd3;   floor_v = 8'd200; end  // floor above the cap
                4:       begin cap = 8'($urandom_range(1, 255)); floor_v = 8'($urandom); end
                default: begin cap = 8'd255; floor_v = 8'd0;   end
            endcase
            program_limits(cap, floor_v);
            if (phase == 1) begin
                // receiver stalls for a long stretch while the sender keeps pushing
                hold_asked <= hold_asked + 1;
                tx_steady  = 60;
            end
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
                run_episode();
        end

        wait_drained();
        repeat (PIPE_LATENCY + 20) @(posedge aclk);
        @(negedge aclk);
        $display("drove %0d items over %0d limit settings, compared %0d results",
                 items_sent, settings_used, results_checked);
        $display("ticks, commands, stops and ignored kinds with random idling on both sides");
        if (mismatches == 0) begin
            $display("timed_pump_valve_sequencer_unit verification clean");
        end else begin
            $display("timed_pump_valve_sequencer_unit verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/tpvs_pkg.sv
rtl/tpvs_cfg.sv
rtl/tpvs_core.sv
rtl/timed_pump_valve_sequencer_unit.sv
rtl/tpvs_checker.sv
bench/timed_pump_valve_sequencer_unit_checker.sv
bench/timed_pump_valve_sequencer_unit_tb.sv
